// ===== hw/rtl/sbq_pkg.sv =====
`default_nettype none

package sbq_pkg;

  localparam logic [1:0] OP_BLOCK  = 2'd0;
  localparam logic [1:0] OP_WAKE   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  localparam int KEY_W  = 32;
  localparam int PROC_W = 5;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [PROC_W-1:0] pid;
  } req_t;

  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic              hit;
    logic              pool_err;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbq_table.sv =====
`default_nettype none

module sbq_table #(
  parameter int MAX_PROCS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  sbq_pkg::req_t req,
  output sbq_pkg::res_t res
);

  localparam int IW = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;

  // descriptor side
  logic [MAX_PROCS-1:0]     desc_in_use;
  logic [sbq_pkg::KEY_W-1:0] desc_key [MAX_PROCS];
  logic [IW-1:0]            queue_head [MAX_PROCS];
  logic [IW-1:0]            queue_tail [MAX_PROCS];
  // process side
  logic [MAX_PROCS-1:0]     proc_is_blocked;
  logic [IW-1:0]            proc_fwd [MAX_PROCS];
  logic [IW-1:0]            proc_bwd [MAX_PROCS];
  logic [IW-1:0]            proc_blocked_on [MAX_PROCS];

  logic          pid_ok;
  logic [IW-1:0] pidx;
  logic          found;
  logic [IW-1:0] fd;
  logic          have_free;
  logic [IW-1:0] fr;
  logic          do_unlink;
  logic [IW-1:0] up;
  logic [IW-1:0] ud;
  logic [IW-1:0] uh;
  logic [IW-1:0] ut;
  logic [IW-1:0] upr;
  logic [IW-1:0] unx;

  logic          use_we;
  logic [IW-1:0] use_wa;
  logic          use_wd;
  logic          blk_we;
  logic [IW-1:0] blk_wa;
  logic          blk_wd;
  logic          key_we;
  logic [IW-1:0] key_wa;
  logic          head_we;
  logic [IW-1:0] head_wa;
  logic [IW-1:0] head_wd;
  logic          tail_we;
  logic [IW-1:0] tail_wa;
  logic [IW-1:0] tail_wd;
  logic          fwd_we;
  logic [IW-1:0] fwd_wa;
  logic [IW-1:0] fwd_wd;
  logic          bwd_we;
  logic [IW-1:0] bwd_wa;
  logic [IW-1:0] bwd_wd;
  logic          bon_we;
  logic [IW-1:0] bon_wa;
  logic [IW-1:0] bon_wd;

  assign pid_ok = int'(req.pid) < MAX_PROCS;
  assign pidx   = IW'(req.pid);

  // key match and first free slot; scan downward so the lowest index wins
  always_comb begin
    found     = 1'b0;
    fd        = '0;
    have_free = 1'b0;
    fr        = '0;
    for (int d = MAX_PROCS - 1; d >= 0; d--) begin
      if (desc_in_use[d] && (desc_key[d] == req.key)) begin
        found = 1'b1;
        fd    = IW'(d);
      end
      if (!desc_in_use[d]) begin
        have_free = 1'b1;
        fr        = IW'(d);
      end
    end
  end

  // unlink target: queue head on wake, given process on remove
  assign up  = (req.op == sbq_pkg::OP_WAKE) ? queue_head[fd] : pidx;
  assign ud  = (req.op == sbq_pkg::OP_WAKE) ? fd : proc_blocked_on[pidx];
  assign uh  = queue_head[ud];
  assign ut  = queue_tail[ud];
  assign upr = proc_bwd[up];
  assign unx = proc_fwd[up];

  always_comb begin
    res       = '0;
    do_unlink = 1'b0;
    use_we    = 1'b0;
    use_wa    = '0;
    use_wd    = 1'b0;
    blk_we    = 1'b0;
    blk_wa    = '0;
    blk_wd    = 1'b0;
    key_we    = 1'b0;
    key_wa    = '0;
    head_we   = 1'b0;
    head_wa   = '0;
    head_wd   = '0;
    tail_we   = 1'b0;
    tail_wa   = '0;
    tail_wd   = '0;
    fwd_we    = 1'b0;
    fwd_wa    = '0;
    fwd_wd    = '0;
    bwd_we    = 1'b0;
    bwd_wa    = '0;
    bwd_wd    = '0;
    bon_we    = 1'b0;
    bon_wa    = '0;
    bon_wd    = '0;

    case (req.op)
      sbq_pkg::OP_BLOCK: begin
        if (pid_ok && !proc_is_blocked[pidx]) begin
          if (found) begin
            // append behind the current tail
            fwd_we  = 1'b1;
            fwd_wa  = queue_tail[fd];
            fwd_wd  = pidx;
            bwd_we  = 1'b1;
            bwd_wa  = pidx;
            bwd_wd  = queue_tail[fd];
            tail_we = 1'b1;
            tail_wa = fd;
            tail_wd = pidx;
            bon_we  = 1'b1;
            bon_wa  = pidx;
            bon_wd  = fd;
            blk_we  = 1'b1;
            blk_wa  = pidx;
            blk_wd  = 1'b1;
          end else if (have_free) begin
            use_we  = 1'b1;
            use_wa  = fr;
            use_wd  = 1'b1;
            key_we  = 1'b1;
            key_wa  = fr;
            head_we = 1'b1;
            head_wa = fr;
            head_wd = pidx;
            tail_we = 1'b1;
            tail_wa = fr;
            tail_wd = pidx;
            bon_we  = 1'b1;
            bon_wa  = pidx;
            bon_wd  = fr;
            blk_we  = 1'b1;
            blk_wa  = pidx;
            blk_wd  = 1'b1;
          end else begin
            res.pool_err = 1'b1;
          end
        end
      end
      sbq_pkg::OP_WAKE: begin
        if (found) begin
          do_unlink = 1'b1;
          res.proc  = sbq_pkg::PROC_W'(queue_head[fd]);
          res.hit   = 1'b1;
        end
      end
      sbq_pkg::OP_REMOVE: begin
        if (pid_ok && proc_is_blocked[pidx]) begin
          do_unlink = 1'b1;
          res.proc  = req.pid;
          res.hit   = 1'b1;
        end
      end
      sbq_pkg::OP_PEEK: begin
        if (found) begin
          res.proc = sbq_pkg::PROC_W'(queue_head[fd]);
          res.hit  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_unlink) begin
      blk_we = 1'b1;
      blk_wa = up;
      blk_wd = 1'b0;
      if ((uh == up) && (ut == up)) begin
        // last waiter gone: free the descriptor
        use_we = 1'b1;
        use_wa = ud;
        use_wd = 1'b0;
      end else if (uh == up) begin
        head_we = 1'b1;
        head_wa = ud;
        head_wd = unx;
      end else if (ut == up) begin
        tail_we = 1'b1;
        tail_wa = ud;
        tail_wd = upr;
      end else begin
        fwd_we = 1'b1;
        fwd_wa = upr;
        fwd_wd = unx;
        bwd_we = 1'b1;
        bwd_wa = unx;
        bwd_wd = upr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_in_use     <= '0;
      proc_is_blocked <= '0;
    end else if (go) begin
      if (use_we) begin
        desc_in_use[use_wa] <= use_wd;
      end
      if (blk_we) begin
        proc_is_blocked[blk_wa] <= blk_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (key_we) begin
        desc_key[key_wa] <= req.key;
      end
      if (head_we) begin
        queue_head[head_wa] <= head_wd;
      end
      if (tail_we) begin
        queue_tail[tail_wa] <= tail_wd;
      end
      if (fwd_we) begin
        proc_fwd[fwd_wa] <= fwd_wd;
      end
      if (bwd_we) begin
        proc_bwd[bwd_wa] <= bwd_wd;
      end
      if (bon_we) begin
        proc_blocked_on[bon_wa] <= bon_wd;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/semaphore_blocked_queue_table_unit.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  opcode, sem_key, proc_id
// result    out        res_valid/res_stall  out_proc, out_valid, pool_empty_error
//
// One request enters per cycle while the result is not stalled. The transfer loads the
// input register, and the result register is loaded from it once the result slot is
// free, together with res_valid. The table lookup and list update sit in one
// combinational pass over flip-flop state between them.
// Synchronous reset empties the descriptor pool and the blocked set at once.
// A stalled result holds the request register; in_stall rises only then.
`default_nettype none

module semaphore_blocked_queue_table_unit #(
  parameter int MAX_PROCS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] sem_key,
  input  logic [4:0]  proc_id,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [4:0]  out_proc,
  output logic        out_valid,
  output logic        pool_empty_error
);

  logic          in_v;
  sbq_pkg::req_t in_req;
  sbq_pkg::res_t res;
  logic          go;
  logic          take;

  assign go       = in_v && (!res_valid || !res_stall);
  assign in_stall = in_v && !go;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (take) begin
      in_v <= 1'b1;
    end else if (go) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_req <= '{op: opcode, key: sem_key, pid: proc_id};
    end
  end

  sbq_table #(
    .MAX_PROCS(MAX_PROCS)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .go (go),
    .req(in_req),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (go) begin
      out_proc         <= res.proc;
      out_valid        <= res.hit;
      pool_empty_error <= res.pool_err;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbq_checker.sv =====
`default_nettype none

module sbq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic [31:0] sem_key,
  input logic [4:0]  proc_id,
  input logic        res_valid,
  input logic        res_stall,
  input logic [4:0]  out_proc,
  input logic        out_valid,
  input logic        pool_empty_error
);

  // a stalled result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_proc) && $stable(out_valid)
      && $stable(pool_empty_error))
    else $error("result changed under stall");

  // no process reported without a hit
  a_proc_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_proc == 5'd0)
    else $error("out_proc nonzero on miss");

  // pool error only on a block, which reports no process
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid && pool_empty_error |-> !out_valid)
    else $error("pool error together with a hit");

  // with the result slot free, requests never stall
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !in_stall)
    else $error("request stalled with empty result slot");

  // reset leaves both sides empty
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind semaphore_blocked_queue_table_unit sbq_checker u_sbq_checker (.*);

`default_nettype wire
